// ----- rtl/aging_page_replacement_assert.svh -----
// Assertion macros used by the page replacement controller (apr_ctrl).
// Each expects clk and rst_n in scope.
`ifndef AGING_PAGE_REPLACEMENT_ASSERT_SVH
`define AGING_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication.
`define APR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/apr_pkg.sv -----
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants of the aging page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apr_pkg;

  localparam int NPAGES  = 256;
  localparam int NFRAMES = 64;
  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 6;
  localparam int FCNT_W  = 7;
  localparam int ADDR_W  = 40;
  localparam int CNT_W   = 32;
  localparam int REF_W   = 4;
  localparam int GRP_W   = 3;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 7;

  localparam logic [REF_W-1:0]  LOAD_REF  = 4'd3;
  localparam logic [REF_W-1:0]  REF_CAP   = 4'd10;
  localparam logic [5:0]        VBITS_RST = 6'd16;
  localparam logic [5:0]        PBITS_RST = 6'd8;
  localparam logic [FCNT_W-1:0] FCNT_RST  = 7'd4;

  localparam logic [CFG_IW-1:0] CFG_VBITS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_PBITS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FCNT  = 2'd2;

  typedef enum logic [1:0] {
    OC_HIT     = 2'd0,
    OC_FREE    = 2'd1,
    OC_REPLACE = 2'd2,
    OC_ERROR   = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ROUTE, S_AGE, S_AGE_TAIL, S_LOOK, S_HIT_RD, S_HIT_WR,
    S_FREE, S_LOAD, S_VIC, S_VIC_TAIL, S_VIC_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               dirty;
    logic [REF_W-1:0]   refcnt;
    logic [CNT_W-1:0]   arrival;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic check;
    logic scan_rd;
    logic age_en;
    logic vic_en;
    logic hit_rd;
    logic hit_wr;
    logic free_step;
    logic load_free;
    logic load_vic;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic age_due;
    logic pg_present;
    logic idx_last;
    logic free_found;
    logic free_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/apr_ram.sv -----
// ----------------------------------------------------------------------------
// apr_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/apr_ctrl.sv -----
// ----------------------------------------------------------------------------
// apr_ctrl
// Sequencer: walks each access through the address check, aging when due,
// lookup, free search and victim search as needed, and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "aging_page_replacement_assert.svh"

module apr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire apr_pkg::sts_t sts,
  output apr_pkg::cmd_t      cmd
);

  apr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      apr_pkg::S_IDLE:     if (in_valid) state_nxt = apr_pkg::S_CHECK;
      apr_pkg::S_CHECK:    state_nxt = sts.err ? apr_pkg::S_DONE : apr_pkg::S_ROUTE;
      apr_pkg::S_ROUTE:    state_nxt = sts.age_due ? apr_pkg::S_AGE : apr_pkg::S_LOOK;
      apr_pkg::S_AGE:      if (sts.idx_last) state_nxt = apr_pkg::S_AGE_TAIL;
      apr_pkg::S_AGE_TAIL: state_nxt = apr_pkg::S_LOOK;
      apr_pkg::S_LOOK:     state_nxt = sts.pg_present ? apr_pkg::S_HIT_RD : apr_pkg::S_FREE;
      apr_pkg::S_HIT_RD:   state_nxt = apr_pkg::S_HIT_WR;
      apr_pkg::S_HIT_WR:   state_nxt = apr_pkg::S_DONE;
      apr_pkg::S_FREE: begin
        if (sts.free_found) state_nxt = apr_pkg::S_LOAD;
        else if (sts.free_last) state_nxt = apr_pkg::S_VIC;
      end
      apr_pkg::S_LOAD:     state_nxt = apr_pkg::S_DONE;
      apr_pkg::S_VIC:      if (sts.idx_last) state_nxt = apr_pkg::S_VIC_TAIL;
      apr_pkg::S_VIC_TAIL: state_nxt = apr_pkg::S_VIC_WR;
      apr_pkg::S_VIC_WR:   state_nxt = apr_pkg::S_DONE;
      apr_pkg::S_DONE:     if (!sts.out_busy) state_nxt = apr_pkg::S_IDLE;
      default:             state_nxt = apr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      apr_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      apr_pkg::S_CHECK:    cmd.check = 1'b1;
      apr_pkg::S_AGE: begin
        cmd.scan_rd = 1'b1;
        cmd.age_en  = 1'b1;
      end
      apr_pkg::S_AGE_TAIL: cmd.age_en = 1'b1;
      apr_pkg::S_HIT_RD:   cmd.hit_rd = 1'b1;
      apr_pkg::S_HIT_WR:   cmd.hit_wr = 1'b1;
      apr_pkg::S_FREE:     cmd.free_step = 1'b1;
      apr_pkg::S_LOAD:     cmd.load_free = 1'b1;
      apr_pkg::S_VIC: begin
        cmd.scan_rd = 1'b1;
        cmd.vic_en  = 1'b1;
      end
      apr_pkg::S_VIC_TAIL: cmd.vic_en = 1'b1;
      apr_pkg::S_VIC_WR:   cmd.load_vic = 1'b1;
      apr_pkg::S_DONE:     cmd.emit = !sts.out_busy;
      default:             cmd = '0;
    endcase
  end

  `APR_ASSERT_NXT(a_age_tail, (state_r == apr_pkg::S_AGE) && sts.idx_last,
    state_r == apr_pkg::S_AGE_TAIL, "aging scan did not finish with its tail")
  `APR_ASSERT_NXT(a_err_skip, (state_r == apr_pkg::S_CHECK) && sts.err,
    state_r == apr_pkg::S_DONE, "address error did not go straight to result")
  `APR_ASSERT_NXT(a_free_load, (state_r == apr_pkg::S_FREE) && sts.free_found,
    state_r == apr_pkg::S_LOAD, "free frame found but not loaded")

endmodule

`default_nettype wire

// ----- rtl/apr_dp.sv -----
// ----------------------------------------------------------------------------
// apr_dp
// Datapath: config registers, page table RAM, present and frame-used bits,
// victim trackers, running counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire apr_pkg::cmd_t                 cmd,
  output apr_pkg::sts_t                      sts,
  input  wire logic                          cfg_valid,
  input  wire logic [apr_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [apr_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic [apr_pkg::ADDR_W-1:0]    in_address,
  input  wire logic                          in_is_write,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    out_outcome,
  output logic      [apr_pkg::FRAME_W-1:0]   out_frame_index,
  output logic      [apr_pkg::PAGE_W-1:0]    out_victim_page,
  output logic                               out_victim_written_back,
  output logic      [apr_pkg::CNT_W-1:0]     out_access_total,
  output logic      [apr_pkg::CNT_W-1:0]     out_replace_total,
  output logic      [apr_pkg::CNT_W-1:0]     out_writeback_total
);

  // configuration
  logic [5:0]                    vbits_r, pbits_r;
  logic [apr_pkg::FCNT_W-1:0]    fcnt_r, nf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= apr_pkg::VBITS_RST;
      pbits_r <= apr_pkg::PBITS_RST;
      fcnt_r  <= apr_pkg::FCNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        apr_pkg::CFG_VBITS: vbits_r <= cfg_data[5:0];
        apr_pkg::CFG_PBITS: pbits_r <= cfg_data[5:0];
        apr_pkg::CFG_FCNT:  fcnt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fcnt_r == '0) nf = 7'd1;
    else if (fcnt_r > 7'(apr_pkg::NFRAMES)) nf = 7'(apr_pkg::NFRAMES);
    else nf = fcnt_r;
  end

  // accepted item
  logic [apr_pkg::ADDR_W-1:0] pn_r;
  logic                       wr_r;
  logic [apr_pkg::PAGE_W-1:0] pg;
  logic [5:0]                 span;
  logic [3:0]                 lim_bits;
  logic                       err;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pn_r <= in_address >> pbits_r;
      wr_r <= in_is_write;
    end
  end

  assign pg       = pn_r[apr_pkg::PAGE_W-1:0];
  assign span     = vbits_r - pbits_r;
  assign lim_bits = (span >= 6'(apr_pkg::PAGE_W)) ? 4'(apr_pkg::PAGE_W) : span[3:0];
  assign err      = (pbits_r > vbits_r) || ((pn_r >> lim_bits) != '0);

  // page table RAM and flags
  logic [apr_pkg::NPAGES-1:0]  present_r;
  logic [apr_pkg::NFRAMES-1:0] used_r;
  logic                        ram_we;
  logic [apr_pkg::PAGE_W-1:0]  ram_waddr, ram_raddr;
  apr_pkg::entry_t             ram_wdata, rdata;

  apr_ram #(.W($bits(apr_pkg::entry_t)), .D(apr_pkg::NPAGES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // scan index and read pipeline
  logic [apr_pkg::PAGE_W-1:0] idx_r, pidx_r;
  logic                       pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      pv_r <= cmd.scan_rd;
      if (cmd.check) idx_r <= '0;
      else if (cmd.scan_rd) idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
  end

  assign ram_raddr = cmd.hit_rd ? pg : idx_r;

  logic pvalid;
  assign pvalid = pv_r && present_r[pidx_r];

  // free frame search, eight frames a cycle
  logic [apr_pkg::GRP_W-1:0]   fg_r;
  logic [apr_pkg::FRAME_W-1:0] ff_r, ff_cand;
  logic                        ff_found;

  always_comb begin
    logic [apr_pkg::FRAME_W-1:0] fi;
    ff_found = 1'b0;
    ff_cand  = '0;
    for (int j = 7; j >= 0; j--) begin
      fi = {fg_r, 3'(j)};
      if (!used_r[fi] && ({1'b0, fi} < nf)) begin
        ff_found = 1'b1;
        ff_cand  = fi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= '0;
    end else if (cmd.check) begin
      fg_r <= '0;
    end else if (cmd.free_step && !ff_found) begin
      fg_r <= fg_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.free_step && ff_found) ff_r <= ff_cand;
  end

  // victim trackers: oldest with count zero, and oldest overall
  logic                        f0_r, f1_r, d0_r, d1_r;
  logic [apr_pkg::PAGE_W-1:0]  b0_r, b1_r;
  logic [apr_pkg::CNT_W-1:0]   t0_r, t1_r;
  logic [apr_pkg::FRAME_W-1:0] fr0_r, fr1_r;
  logic                        take0, take1;

  assign take0 = cmd.vic_en && pvalid && (rdata.refcnt == '0) &&
                 (!f0_r || (rdata.arrival < t0_r));
  assign take1 = cmd.vic_en && pvalid && (!f1_r || (rdata.arrival < t1_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_r <= 1'b0;
      f1_r <= 1'b0;
    end else if (cmd.check) begin
      f0_r <= 1'b0;
      f1_r <= 1'b0;
    end else begin
      if (take0) f0_r <= 1'b1;
      if (take1) f1_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take0) begin
      b0_r  <= pidx_r;
      t0_r  <= rdata.arrival;
      fr0_r <= rdata.frame;
      d0_r  <= rdata.dirty;
    end
    if (take1) begin
      b1_r  <= pidx_r;
      t1_r  <= rdata.arrival;
      fr1_r <= rdata.frame;
      d1_r  <= rdata.dirty;
    end
  end

  logic [apr_pkg::PAGE_W-1:0]  vic;
  logic [apr_pkg::FRAME_W-1:0] vic_fr;
  logic                        vic_d;
  assign vic    = f0_r ? b0_r  : b1_r;
  assign vic_fr = f0_r ? fr0_r : fr1_r;
  assign vic_d  = f0_r ? d0_r  : d1_r;

  // RAM write port
  logic [apr_pkg::CNT_W-1:0] acc_r, arr_r, rep_r, wb_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pg;
    ram_wdata = rdata;
    if (cmd.age_en) begin
      ram_we           = pvalid && (rdata.refcnt != '0);
      ram_waddr        = pidx_r;
      ram_wdata.refcnt = rdata.refcnt - 1'b1;
    end else if (cmd.hit_wr) begin
      ram_we = 1'b1;
      if (rdata.refcnt < apr_pkg::REF_CAP) ram_wdata.refcnt = rdata.refcnt + 1'b1;
      ram_wdata.dirty = rdata.dirty | wr_r;
    end else if (cmd.load_free || cmd.load_vic) begin
      ram_we            = 1'b1;
      ram_wdata.frame   = cmd.load_free ? ff_r : vic_fr;
      ram_wdata.dirty   = wr_r;
      ram_wdata.refcnt  = apr_pkg::LOAD_REF;
      ram_wdata.arrival = arr_r;
    end
  end

  // flags and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      used_r    <= '0;
      acc_r     <= '0;
      arr_r     <= '0;
      rep_r     <= '0;
      wb_r      <= '0;
    end else begin
      if (cmd.check && !err) acc_r <= acc_r + 1'b1;
      if (cmd.load_free) begin
        present_r[pg] <= 1'b1;
        used_r[ff_r]  <= 1'b1;
        arr_r         <= arr_r + 1'b1;
      end
      if (cmd.load_vic) begin
        present_r[vic] <= 1'b0;
        present_r[pg]  <= 1'b1;
        used_r[vic_fr] <= 1'b1;
        arr_r          <= arr_r + 1'b1;
        rep_r          <= rep_r + 1'b1;
        if (vic_d) wb_r <= wb_r + 1'b1;
      end
    end
  end

  // per-item result
  logic [1:0]                  res_oc_r;
  logic [apr_pkg::FRAME_W-1:0] res_fi_r;
  logic [apr_pkg::PAGE_W-1:0]  res_vp_r;
  logic                        res_wb_r;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_oc_r <= apr_pkg::OC_ERROR;
      res_fi_r <= '0;
      res_vp_r <= '0;
      res_wb_r <= 1'b0;
    end
    if (cmd.hit_wr) begin
      res_oc_r <= apr_pkg::OC_HIT;
      res_fi_r <= rdata.frame;
    end
    if (cmd.load_free) begin
      res_oc_r <= apr_pkg::OC_FREE;
      res_fi_r <= ff_r;
    end
    if (cmd.load_vic) begin
      res_oc_r <= apr_pkg::OC_REPLACE;
      res_fi_r <= vic_fr;
      res_vp_r <= vic;
      res_wb_r <= vic_d;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_outcome             <= res_oc_r;
      out_frame_index         <= res_fi_r;
      out_victim_page         <= res_vp_r;
      out_victim_written_back <= res_wb_r;
      out_access_total        <= acc_r;
      out_replace_total       <= rep_r;
      out_writeback_total     <= wb_r;
    end
  end

  assign sts.err        = err;
  assign sts.age_due    = (acc_r[1:0] == 2'b00);
  assign sts.pg_present = present_r[pg];
  assign sts.idx_last   = (idx_r == '1);
  assign sts.free_found = ff_found;
  assign sts.free_last  = (fg_r == '1);
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

`default_nettype wire

// ----- rtl/aging_page_replacement.sv -----
// Paths per access: address error, hit, free-frame load and replacement;
// every path but the address error adds an aging pass on every fourth valid
// access. One access at a time; the page table RAM scan (one entry a cycle)
// serves the aging pass and the victim search. Reset is synchronous, active
// low: all pages absent, all frames free, counters zero, no clearing pass.
// ----------------------------------------------------------------------------
// aging_page_replacement
// Demand paging with reference-count aging and oldest-first replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aging_page_replacement (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [apr_pkg::CFG_IW-1:0]    cfg_index,
  input  wire logic [apr_pkg::CFG_DW-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [apr_pkg::ADDR_W-1:0]    in_address,
  input  wire logic                          in_is_write,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    out_outcome,
  output logic      [apr_pkg::FRAME_W-1:0]   out_frame_index,
  output logic      [apr_pkg::PAGE_W-1:0]    out_victim_page,
  output logic                               out_victim_written_back,
  output logic      [apr_pkg::CNT_W-1:0]     out_access_total,
  output logic      [apr_pkg::CNT_W-1:0]     out_replace_total,
  output logic      [apr_pkg::CNT_W-1:0]     out_writeback_total
);

  apr_pkg::cmd_t cmd;
  apr_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  apr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  apr_dp u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .cfg_valid               (cfg_valid),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_address              (in_address),
    .in_is_write             (in_is_write),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_outcome             (out_outcome),
    .out_frame_index         (out_frame_index),
    .out_victim_page         (out_victim_page),
    .out_victim_written_back (out_victim_written_back),
    .out_access_total        (out_access_total),
    .out_replace_total       (out_replace_total),
    .out_writeback_total     (out_writeback_total)
  );

endmodule

`default_nettype wire
